// ----- hw/rtl/iib_pkg.sv -----
// ----------------------------------------------------------------------------
// iib_pkg
// Shared types and codes of the indexed insert buffer: request and result
// payloads, operation and status codes, controller states and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package iib_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int IDX_W        = 7;
  localparam int WORD_W       = 32;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_BOUNDS = 2'd1,
    STAT_FULL   = 2'd2
  } stat_t;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [WORD_W-1:0] value;
    logic [IDX_W-1:0]         index;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] read_data;
    logic [IDX_W-1:0]         entry_count;
    logic                     is_empty;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_INS_WR,
    S_RD_WAIT
  } state_t;

  // Datapath commands
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,        // capture the request
    CMD_APPEND,      // write value at count, count up
    CMD_INSERT_AT,   // write value at index, count up
    CMD_SHIFT_START, // point at the last entry and read it
    CMD_SHIFT,       // move the entry read one place up, step down
    CMD_READ_START   // read the entry at index
  } cmd_t;

  typedef enum logic [1:0] {
    DSEL_ZERO,
    DSEL_EMPTY,
    DSEL_MEM
  } dsel_t;

  typedef struct packed {
    cmd_t  cmd;
    logic  respond;
    stat_t status;
    dsel_t data_sel;
  } ctl_t;

  typedef struct packed {
    logic [1:0] op;
    logic       idx_gt_cnt;
    logic       idx_ge_cnt;
    logic       full;
    logic       ptr_at_idx;
  } sts_t;

endpackage

// ----- hw/rtl/indexed_insert_buffer.sv -----
// ----------------------------------------------------------------------------
// indexed_insert_buffer
// Fixed-capacity ordered store of signed 32-bit words with append, insert at
// index and read at index; one result per request.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge where start is high and busy is low.
// Every request gives exactly one result, shown on out_rsp for a single
// cycle with out_valid high; the receiver cannot stall it, so sample it then.
// busy is already low in the cycle the result shows, so the next request may
// be issued in that cycle. Append, an insert at the end, an unused code and
// any rejected request (bad index or full store) are answered from the decode
// state; a read waits for the memory read; an inner insert moves the entries
// from the last down to the index one place up, then writes the value. Insert
// moves one entry per cycle through the entry memory's single read and
// single write port, which sets its length. A read with an index at or past
// the count returns STAT_BOUNDS and the configured empty value. Write the
// empty value only while busy is low and no result is pending.
module indexed_insert_buffer
  import iib_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)(
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              start,
  output logic              busy,
  input  req_t              in_req,
  // result channel
  output logic              out_valid,
  output rsp_t              out_rsp,
  // configuration: empty value
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata
);

  ctl_t ctl;
  sts_t sts;

  // Sequence each request: decode, shift loop, final write, result strobe.
  iib_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // Hold entries, count and result register; act on controller commands.
  iib_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

// ----- hw/rtl/iib_ctrl.sv -----
// ----------------------------------------------------------------------------
// iib_ctrl
// Controller of the indexed insert buffer: sequences each request and drives
// the datapath by commands.
// ----------------------------------------------------------------------------
module iib_ctrl
  import iib_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  sts_t   sts,
  output ctl_t   ctl,
  output logic   busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (sts.op == OP_INSERT && !sts.idx_gt_cnt && !sts.full && !sts.idx_ge_cnt) begin
          state_nxt = S_SHIFT;
        end else if (sts.op == OP_READ && !sts.idx_ge_cnt) begin
          state_nxt = S_RD_WAIT;
        end
      end
      S_SHIFT: begin
        if (sts.ptr_at_idx) begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR:  state_nxt = S_IDLE;
      S_RD_WAIT: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl.cmd      = CMD_NONE;
    ctl.respond  = 1'b0;
    ctl.status   = STAT_DONE;
    ctl.data_sel = DSEL_ZERO;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.cmd = CMD_LOAD;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_APPEND: begin
            ctl.respond = 1'b1;
            if (sts.full) begin
              ctl.status = STAT_FULL;
            end else begin
              ctl.cmd = CMD_APPEND;
            end
          end
          OP_INSERT: begin
            if (sts.idx_gt_cnt) begin
              ctl.respond = 1'b1;
              ctl.status  = STAT_BOUNDS;
            end else if (sts.full) begin
              ctl.respond = 1'b1;
              ctl.status  = STAT_FULL;
            end else if (sts.idx_ge_cnt) begin
              ctl.cmd     = CMD_INSERT_AT;
              ctl.respond = 1'b1;
            end else begin
              ctl.cmd = CMD_SHIFT_START;
            end
          end
          OP_READ: begin
            if (sts.idx_ge_cnt) begin
              ctl.respond  = 1'b1;
              ctl.status   = STAT_BOUNDS;
              ctl.data_sel = DSEL_EMPTY;
            end else begin
              ctl.cmd = CMD_READ_START;
            end
          end
          default: ctl.respond = 1'b1;
        endcase
      end
      S_SHIFT: ctl.cmd = CMD_SHIFT;
      S_INS_WR: begin
        ctl.cmd     = CMD_INSERT_AT;
        ctl.respond = 1'b1;
      end
      S_RD_WAIT: begin
        ctl.respond  = 1'b1;
        ctl.data_sel = DSEL_MEM;
      end
      default: ctl.cmd = CMD_NONE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- hw/rtl/iib_dpath.sv -----
// ----------------------------------------------------------------------------
// iib_dpath
// Datapath of the indexed insert buffer: entry memory, count, request and
// result registers, shift pointer and the configured empty value.
// ----------------------------------------------------------------------------
module iib_dpath
  import iib_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)(
  input  logic              clk,
  input  logic              rst_n,
  input  req_t              in_req,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata,
  input  ctl_t              ctl,
  output sts_t              sts,
  output logic              out_valid,
  output rsp_t              out_rsp
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  logic [WORD_W-1:0] mem [CAPACITY];
  logic [WORD_W-1:0] rd_data_r;
  logic [WORD_W-1:0] empty_value_r;
  req_t              req_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic              out_valid_r;
  rsp_t              rsp_r;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     idx_addr;
  logic [CMPW-1:0]   idx_ext, cnt_ext;
  logic [WORD_W-1:0] rsp_data;

  assign idx_addr = AW'(req_r.index);
  assign idx_ext  = CMPW'(req_r.index);
  assign cnt_ext  = CMPW'(count_r);

  assign sts.op         = req_r.operation;
  assign sts.idx_gt_cnt = (idx_ext > cnt_ext);
  assign sts.idx_ge_cnt = (idx_ext >= cnt_ext);
  assign sts.full       = (count_r == CW'(CAPACITY));
  assign sts.ptr_at_idx = (ptr_r == idx_addr);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_addr;
    mem_wdata = req_r.value;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    unique case (ctl.cmd)
      CMD_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(count_r);
        count_nxt = count_r + CW'(1);
      end
      CMD_INSERT_AT: begin
        mem_we    = 1'b1;
        count_nxt = count_r + CW'(1);
      end
      CMD_SHIFT_START: ptr_nxt = AW'(count_r - CW'(1));
      CMD_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r + AW'(1);
        mem_wdata = rd_data_r;
        ptr_nxt   = ptr_r - AW'(1);
      end
      CMD_READ_START: ptr_nxt = idx_addr;
      default: ptr_nxt = ptr_r;
    endcase
  end

  // Entry memory: one write port, one registered read port at the next pointer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[ptr_nxt];
  end

  always_comb begin
    case (ctl.data_sel)
      DSEL_EMPTY: rsp_data = empty_value_r;
      DSEL_MEM:   rsp_data = rd_data_r;
      default:    rsp_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      empty_value_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= ctl.respond;
      if (cfg_we) begin
        empty_value_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (ctl.cmd == CMD_LOAD) begin
      req_r <= in_req;
    end
    if (ctl.respond) begin
      rsp_r.status      <= ctl.status;
      rsp_r.read_data   <= rsp_data;
      rsp_r.entry_count <= IDX_W'(count_nxt);
      rsp_r.is_empty    <= (count_nxt == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

endmodule

// ----- hw/rtl/iib_chk.sv -----
// ----------------------------------------------------------------------------
// iib_chk
// Port-level checks of the indexed insert buffer, bound to the top level.
// ----------------------------------------------------------------------------
module iib_chk
  import iib_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input rsp_t              out_rsp
);

  // An accepted request keeps the block busy in the next cycle
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // A result shows only once the request is finished
  a_result_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // No result without a request in flight
  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !out_valid)
    else $error("result without a pending request");

  // Status is a defined code
  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.status == STAT_DONE || out_rsp.status == STAT_BOUNDS ||
                   out_rsp.status == STAT_FULL))
    else $error("undefined status code");

  // A full store is never empty
  a_full_not_empty : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status == STAT_FULL |-> !out_rsp.is_empty)
    else $error("full status on an empty store");

endmodule

bind indexed_insert_buffer iib_chk u_chk (.*);
